@@ src/assert_macros.svh @@
// assertion macros for the checker file ctcg_checker.sv
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/ctcg_pkg.sv @@
// shared constants for the ctc greedy decoder
// no dependencies; used by the channel interfaces and the core
package ctcg_pkg;

    localparam int MAX_CLASSES_DEF = 8192;

    localparam int SCORE_W = 16;
    localparam int CHAR_W  = 13;
    localparam int KEY_W   = 14;

    localparam logic [KEY_W-1:0] KEY_COUNT_RST = 14'd8192;

    // apb register map: word select bit of paddr
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_KEY_COUNT = 1'b0;

endpackage

@@ src/ctcg_if.sv @@
// valid/ready channels of the ctc greedy decoder: score stream in, character stream out
// depends on ctcg_pkg for field widths
interface ctcg_in_if;
    import ctcg_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SCORE_W-1:0] score;
    logic                      row_end;
    logic                      line_end;

    modport source (output valid, output score, output row_end, output line_end,
                    input ready);
    modport sink   (input valid, input score, input row_end, input line_end,
                    output ready);
endinterface

interface ctcg_out_if;
    import ctcg_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_index;
    logic              has_char;
    logic              last_of_line;

    modport source (output valid, output char_index, output has_char,
                    output last_of_line, input ready);
    modport sink   (input valid, input char_index, input has_char,
                    input last_of_line, output ready);
endinterface

@@ src/ctc_greedy_decode_core.sv @@
// ctc greedy decoder: running argmax per row, collapse of repeats and blanks
// Usage:
//   i_in carries one class score per request (signed Q8.8) with row_end on the
//   last score of a time step and line_end with it on the last row of a line.
//   o_out gives a request for each decoded character and one closing each
//   line (has_char 0 when the last row adds no character).
//   key_count is written over the apb port at address 0; it must only change
//   while no request is in flight.
// An accepted score is held in the input register; its result, if any, moves
//   to the output register when the input register advances.
// Throughput: one score per cycle unless o_out stalls; the row state (column,
//   best score, best column, previous winner) updates in the single stage
//   after the input register, so consecutive scores never wait on each other.
// Reset (synchronous, active low) empties both registers, clears the column and
//   previous winner and restores key_count to 8192.
// When the receiver stalls, the result stays in the output register, one more
//   score is held in the input register, and then i_in.ready drops.
module ctc_greedy_decode_core #(
    parameter int MAX_CLASSES = ctcg_pkg::MAX_CLASSES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ctcg_in_if.sink                             i_in,
    ctcg_out_if.source                          o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ctcg_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ctcg_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ctcg_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import ctcg_pkg::*;

    localparam int COL_W = $clog2(MAX_CLASSES + 1);
    localparam int WIN_W = $clog2(MAX_CLASSES);
    localparam int EXT_A = (WIN_W > KEY_W) ? WIN_W : KEY_W;
    localparam int EXT_W = (EXT_A > CHAR_W) ? EXT_A : CHAR_W;

    // configuration
    logic [KEY_W-1:0] r_key_count;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= KEY_COUNT_RST;
        end else if (psel && penable && pwrite && paddr[2] == REG_KEY_COUNT) begin
            r_key_count <= pwdata[KEY_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_KEY_COUNT) begin
            prdata = APB_DATA_W'(r_key_count);
        end
    end

    // input register
    logic                      r_s1_valid;
    logic signed [SCORE_W-1:0] r_s1_score;
    logic                      r_s1_row_end;
    logic                      r_s1_line_end;
    logic                      s1_adv;
    logic                      in_take;

    assign s1_adv   = r_s1_valid && (!o_out.valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_take  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_score    <= i_in.score;
            r_s1_row_end  <= i_in.row_end;
            r_s1_line_end <= i_in.line_end;
        end
    end

    // row state
    logic [COL_W-1:0]          r_column;
    logic signed [SCORE_W-1:0] r_best_score;
    logic [WIN_W-1:0]          r_best_column;
    logic [WIN_W-1:0]          r_prev_winner;

    logic                      col_live;
    logic                      take_score;
    logic signed [SCORE_W-1:0] cur_score;
    logic [WIN_W-1:0]          cur_column;
    logic [EXT_W-1:0]          winner_ext;
    logic                      is_char;
    logic                      has_result;
    logic [CHAR_W-1:0]         char_val;

    always_comb begin
        col_live   = r_column < COL_W'(MAX_CLASSES);
        take_score = col_live && (r_column == '0 || r_s1_score > r_best_score);
        cur_score  = take_score ? r_s1_score : r_best_score;
        cur_column = take_score ? r_column[WIN_W-1:0] : r_best_column;
        winner_ext = EXT_W'(cur_column);
        is_char    = (cur_column != '0) && (winner_ext < EXT_W'(r_key_count))
                     && (cur_column != r_prev_winner);
        has_result = r_s1_row_end && (is_char || r_s1_line_end);
        char_val   = is_char ? CHAR_W'(winner_ext - EXT_W'(1)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column      <= '0;
            r_prev_winner <= '0;
        end else if (s1_adv) begin
            if (r_s1_row_end) begin
                r_column      <= '0;
                r_prev_winner <= r_s1_line_end ? '0 : cur_column;
            end else if (col_live) begin
                r_column <= r_column + COL_W'(1);
            end
        end
    end

    // the row's first score always loads, so these need no reset
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_best_score  <= cur_score;
            r_best_column <= cur_column;
        end
    end

    // output register
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_has_char;
    logic              r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= has_result;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && has_result) begin
            r_out_char     <= char_val;
            r_out_has_char <= is_char;
            r_out_last     <= r_s1_line_end;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.char_index   = r_out_char;
    assign o_out.has_char     = r_out_has_char;
    assign o_out.last_of_line = r_out_last;

endmodule

@@ src/ctcg_checker.sv @@
// port-level checks for ctc_greedy_decode_core, attached by bind
// depends on ctcg_pkg and assert_macros.svh
`include "assert_macros.svh"

module ctcg_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [ctcg_pkg::CHAR_W-1:0]   i_out_char_index,
    input logic                          i_out_has_char,
    input logic                          i_out_last_of_line
);
    import ctcg_pkg::*;

    // a result without a character only ever closes a line
    `ASSERT_IMPLIES(a_bare_is_line_end, i_clk, i_rst_n, i_out_valid && !i_out_has_char, i_out_last_of_line)

    // a bare line end carries index zero
    `ASSERT_IMPLIES(a_bare_index_zero, i_clk, i_rst_n, i_out_valid && !i_out_has_char, i_out_char_index == '0)

    // stalled request stays up
    `ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // stalled request keeps its payload
    `ASSERT_NEXT(a_out_payload_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_char_index) && $stable(i_out_has_char) && $stable(i_out_last_of_line))

endmodule

bind ctc_greedy_decode_core ctcg_checker u_ctcg_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_char_index   (o_out.char_index),
    .i_out_has_char     (o_out.has_char),
    .i_out_last_of_line (o_out.last_of_line)
);
